// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define BLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define BLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/blc_pkg.sv =====
`default_nettype none

package blc_pkg;

  localparam int WinLen = 13;
  localparam int PosW = 17;
  localparam int CfgIndexW = 1;

  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};
  localparam logic [PosW-1:0] MinCertReset = 17'd256;
  localparam logic [PosW-1:0] MaxCertReset = 17'd2048;

  localparam logic [7:0] DerSeq = 8'h30;
  localparam logic [7:0] DerLong2 = 8'h82;
  localparam logic [7:0] DerShortMax = 8'h80;
  localparam logic [7:0] DerInt = 8'h02;

  // expected byte per window cell: seq tag, length (any short form), then the oid
  localparam logic [7:0] WinRef [WinLen] = '{
    8'h30, 8'h00, 8'h06, 8'h09, 8'h2B, 8'h06, 8'h01,
    8'h04, 8'h01, 8'h82, 8'h26, 8'h01, 8'h01
  };

  typedef enum logic [CfgIndexW-1:0] {
    CfgMinCertSize = 1'b0,
    CfgMaxCertSize = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StNoTag    = 3'd1,
    StBadLen   = 3'd2,
    StSize     = 3'd3,
    StNoSeq    = 3'd4,
    StNoInt    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PsIdle    = 2'd0,
    PsDone    = 2'd1,
    PsMissing = 2'd2
  } parse_t;

endpackage

`default_nettype wire

// ===== sv/blc_if.sv =====
`default_nettype none

interface blc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface blc_result_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic [blc_pkg::PosW-1:0]  cert_size;
  logic [31:0]               image_length;

  modport source (output valid, status, cert_size, image_length, input ready);
  modport sink (input valid, status, cert_size, image_length, output ready);
endinterface

`default_nettype wire

// ===== sv/blc_cell.sv =====
`default_nettype none

module blc_cell (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire logic       clear,
  input  wire logic [7:0] d_in,
  input  wire logic [7:0] ref_byte,
  output logic      [7:0] q,
  output logic            hit
);

  // hit looks at the byte entering the cell
  assign hit = (d_in == ref_byte);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      q <= 8'h00;
    end else if (load) begin
      q <= d_in;
    end
  end

endmodule

`default_nettype wire

// ===== sv/boot_cert_length_parser.sv =====
// Certificate length parser for a signed boot image. Bytes enter on stream one per
// cycle, byte zero of the certificate first; the block accepts a byte in every cycle
// in which its two-entry result buffer has a free slot, so a stream runs at one
// byte per clock. The byte marked last yields one result (status, certificate size,
// image length), registered and shown on result the cycle after that byte is taken
// when the output register is free, later behind an earlier result that waits; the
// next byte starts a new image. The boot-sequence search is a 13-cell shift line in
// which each cell compares the byte entering it, so the match and the trailing
// integer decode complete in the cycle of the byte that completes them. Size window
// registers are user-written via wr_en/wr_index/wr_data only while idle; unchecked.
`default_nettype none
`include "assert_macros.svh"

module boot_cert_length_parser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  blc_byte_if.sink                            stream,
  blc_result_if.source                        result,
  input  wire logic                           wr_en,
  input  wire logic [blc_pkg::CfgIndexW-1:0]  wr_index,
  input  wire logic [blc_pkg::PosW-1:0]       wr_data
);

  localparam int PosW = blc_pkg::PosW;
  localparam int WinLen = blc_pkg::WinLen;

  logic [PosW-1:0] min_cert_size;
  logic [PosW-1:0] max_cert_size;

  logic [PosW-1:0] position, position_next;
  logic [7:0] h0, h1, h2, h0_next, h1_next, h2_next;
  logic [PosW-1:0] cert_total, cert_total_next;
  logic seq_found, seq_found_next;
  logic [PosW-1:0] seq_end, seq_end_next;
  logic [31:0] length_value, length_value_next;
  blc_pkg::parse_t parse_state, parse_state_next;

  logic acc, last;
  logic [7:0] b;

  logic [7:0] win_q [WinLen];
  logic [7:0] win_d [WinLen];
  logic [WinLen-1:0] hits;

  logic match;
  logic [7:0] slen;
  logic [31:0] tail_value;
  logic tail_ok;

  blc_pkg::status_t res_status;
  logic [PosW-1:0] res_size;
  logic [31:0] res_length;

  logic out_valid, skid_valid;
  blc_pkg::status_t out_status, skid_status;
  logic [PosW-1:0] out_size, skid_size;
  logic [31:0] out_length, skid_length;

  logic res_ok, hdr_bad;

  assign b = stream.data_byte;
  assign last = stream.last_byte;
  assign stream.ready = !skid_valid;
  assign acc = stream.valid && stream.ready;

  // window shift line
  for (genvar i = 0; i < WinLen; i++) begin : g_win
    if (i < WinLen - 1) begin : g_mid
      assign win_d[i] = win_q[i+1];
    end else begin : g_end
      assign win_d[i] = b;
    end
    blc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .load     (acc),
      .clear    (acc && last),
      .d_in     (win_d[i]),
      .ref_byte (blc_pkg::WinRef[i]),
      .q        (win_q[i]),
      .hit      (hits[i])
    );
  end

  assign match = !seq_found && (position >= PosW'(WinLen - 1)) &&
                 ({1'b0, position} + 18'd1 < {1'b0, cert_total}) &&
                 hits[0] && (win_d[1] < blc_pkg::DerShortMax) &&
                 (&hits[WinLen-1:2]);
  assign slen = win_d[1];

  always_comb begin
    tail_ok = 1'b1;
    tail_value = 32'd0;
    if (win_d[7] == blc_pkg::DerInt && win_d[8] == 8'd4) begin
      tail_value = {win_d[9], win_d[10], win_d[11], win_d[12]};
    end else if (win_d[8] == blc_pkg::DerInt && win_d[9] == 8'd3) begin
      tail_value = {8'd0, win_d[10], win_d[11], win_d[12]};
    end else if (win_d[9] == blc_pkg::DerInt && win_d[10] == 8'd2) begin
      tail_value = {16'd0, win_d[11], win_d[12]};
    end else if (win_d[10] == blc_pkg::DerInt && win_d[11] == 8'd1) begin
      tail_value = {24'd0, win_d[12]};
    end else begin
      tail_ok = 1'b0;
    end
  end

  always_comb begin
    position_next = (position == blc_pkg::PosMax) ? position : position + PosW'(1);
    h0_next = (position == PosW'(0)) ? b : h0;
    h1_next = (position == PosW'(1)) ? b : h1;
    h2_next = (position == PosW'(2)) ? b : h2;

    cert_total_next = cert_total;
    if (position == PosW'(1) && h0 == blc_pkg::DerSeq && b <= blc_pkg::DerShortMax) begin
      cert_total_next = {9'd0, b} + 17'd2;
    end
    if (position == PosW'(3) && h0 == blc_pkg::DerSeq && h1 == blc_pkg::DerLong2) begin
      cert_total_next = {1'b0, h2, b} + 17'd4;
    end

    seq_found_next = seq_found;
    seq_end_next = seq_end;
    parse_state_next = parse_state;
    length_value_next = length_value;
    if (match) begin
      seq_found_next = 1'b1;
      if (slen < 8'd11) begin
        parse_state_next = blc_pkg::PsMissing;
      end else begin
        seq_end_next = position - 17'd11 + {9'd0, slen};
      end
    end
    if (seq_found_next && parse_state_next == blc_pkg::PsIdle && position == seq_end_next) begin
      if (tail_ok) begin
        length_value_next = tail_value;
        parse_state_next = blc_pkg::PsDone;
      end else begin
        parse_state_next = blc_pkg::PsMissing;
      end
    end

    res_size = '0;
    res_length = '0;
    if (h0_next != blc_pkg::DerSeq) begin
      res_status = blc_pkg::StNoTag;
    end else if (cert_total_next == '0) begin
      res_status = blc_pkg::StBadLen;
    end else begin
      res_size = cert_total_next;
      if (!(cert_total_next > min_cert_size && cert_total_next < max_cert_size)) begin
        res_status = blc_pkg::StSize;
      end else if (!seq_found_next) begin
        res_status = blc_pkg::StNoSeq;
      end else if (parse_state_next != blc_pkg::PsDone) begin
        res_status = blc_pkg::StNoInt;
      end else begin
        res_status = blc_pkg::StOk;
        res_length = length_value_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_cert_size <= blc_pkg::MinCertReset;
      max_cert_size <= blc_pkg::MaxCertReset;
    end else if (wr_en) begin
      case (blc_pkg::cfg_index_t'(wr_index))
        blc_pkg::CfgMinCertSize: min_cert_size <= wr_data;
        blc_pkg::CfgMaxCertSize: max_cert_size <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (acc && last)) begin
      position <= '0;
      h0 <= '0;
      h1 <= '0;
      h2 <= '0;
      cert_total <= '0;
      seq_found <= 1'b0;
      seq_end <= '0;
      length_value <= '0;
      parse_state <= blc_pkg::PsIdle;
    end else if (acc) begin
      position <= position_next;
      h0 <= h0_next;
      h1 <= h1_next;
      h2 <= h2_next;
      cert_total <= cert_total_next;
      seq_found <= seq_found_next;
      seq_end <= seq_end_next;
      length_value <= length_value_next;
      parse_state <= parse_state_next;
    end
  end

  // output register plus skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && result.ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (acc && last) begin
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (acc && last) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && result.ready) begin
      if (skid_valid) begin
        out_status <= skid_status;
        out_size <= skid_size;
        out_length <= skid_length;
      end else begin
        out_status <= res_status;
        out_size <= res_size;
        out_length <= res_length;
      end
    end else if (!out_valid) begin
      out_status <= res_status;
      out_size <= res_size;
      out_length <= res_length;
    end
    if (!skid_valid) begin
      skid_status <= res_status;
      skid_size <= res_size;
      skid_length <= res_length;
    end
  end

  assign result.valid = out_valid;
  assign result.status = out_status;
  assign result.cert_size = out_size;
  assign result.image_length = out_length;

  assign res_ok = (out_status == blc_pkg::StOk);
  assign hdr_bad = (out_status == blc_pkg::StNoTag) || (out_status == blc_pkg::StBadLen);

  `BLC_ASSERT_ALWAYS(a_skid_behind_out, skid_valid |-> out_valid, "skid full with output empty")
  `BLC_ASSERT(a_restart_after_last, (acc && last) |=> (position == '0 && !seq_found), "no restart")
  `BLC_ASSERT(a_length_only_ok, (out_valid && !res_ok) |-> (out_length == '0), "length on error")
  `BLC_ASSERT(a_size_zero_on_header_fail, (out_valid && hdr_bad) |-> (out_size == '0), "size set")

endmodule

`default_nettype wire
